FILE: hw/rtl/tfd_pkg.sv
// Shared constants for the timestamped frame deframer: parser states, event codes, registers.
package tfd_pkg;

	// parser states
	localparam logic [2:0] ST_SYNC0  = 3'd0;
	localparam logic [2:0] ST_SYNC1  = 3'd1;
	localparam logic [2:0] ST_STAMP  = 3'd2;
	localparam logic [2:0] ST_LENGTH = 3'd3;
	localparam logic [2:0] ST_DATA   = 3'd4;
	localparam logic [2:0] ST_END    = 3'd5;
	localparam logic [2:0] ST_HELD   = 3'd6;
	localparam logic [2:0] ST_LOST   = 3'd7;

	// result event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_PAYLOAD = 3'd1;
	localparam logic [2:0] EV_RELEASE = 3'd2;
	localparam logic [2:0] EV_LOST    = 3'd3;
	localparam logic [2:0] EV_DROPPED = 3'd4;

	// input action codes
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_FIRST_SYNC  = 2'd0;
	localparam logic [1:0] CFG_SECOND_SYNC = 2'd1;
	localparam logic [1:0] CFG_CLOSE_BYTE  = 2'd2;

	// configuration reset values
	localparam logic [7:0] FIRST_SYNC_RST  = 8'd165;
	localparam logic [7:0] SECOND_SYNC_RST = 8'd90;
	localparam logic [7:0] CLOSE_BYTE_RST  = 8'd13;

	// timestamp bytes in a frame header
	localparam logic [7:0] STAMP_BYTES = 8'd4;

endpackage

FILE: hw/rtl/timestamped_frame_deframer.sv
// Timestamped frame deframer: byte-stream frame parser with tick-driven playback release.

// Each input beat is either a received byte (action 0) or a playback tick (action 1), and each
// gives exactly one result beat. Frames are: first sync, second sync, four timestamp bytes
// (little-endian), a length byte, that many payload bytes, and an end marker. Payload bytes come
// out as they arrive, with their index; nothing is buffered. A bad sync or end byte gives a
// sync-lost result, the byte after it is swallowed, and hunting restarts at the first sync byte.
// A complete frame is held: bytes received meanwhile are reported as dropped. Every tick bumps a
// 32-bit elapsed count that saturates and is cleared only by reset; the first tick that finds it
// above the held timestamp releases the frame with its stamp and length. Throughput is one beat
// per clock: the beat is captured in an input register, processed in one pass into the result
// register, and the input side keeps taking beats as long as the result register is drained.
// Result valid rises as the beat moves from the input into the result register. Sync and end
// marker values are written through the configuration channel (always ready) and should only
// change while the block is idle.
module timestamped_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  byte_value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [31:0] frame_stamp,
	output logic [7:0]  frame_length,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration registers
	logic [7:0]  first_sync_q;
	logic [7:0]  second_sync_q;
	logic [7:0]  close_byte_q;

	// input register stage
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;

	// parser state
	logic [2:0]  state_q;
	logic [7:0]  count_q;
	logic [31:0] stamp_q;
	logic [7:0]  length_q;
	logic [31:0] elapsed_q;

	// result register
	logic        out_valid_q;
	logic [2:0]  event_q;
	logic [7:0]  pbyte_q;
	logic [7:0]  pindex_q;
	logic [31:0] fstamp_q;
	logic [7:0]  flength_q;

	// next-state and result logic
	logic        advance;
	logic [2:0]  state_d;
	logic [7:0]  count_d;
	logic [31:0] stamp_d;
	logic [7:0]  length_d;
	logic [31:0] elapsed_d;
	logic [2:0]  event_d;
	logic [7:0]  pbyte_d;
	logic [7:0]  pindex_d;
	logic [31:0] fstamp_d;
	logic [7:0]  flength_d;
	logic [7:0]  count_inc;

	// a beat in stage 1 moves on whenever the result register is free or being emptied
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign count_inc = count_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= tfd_pkg::FIRST_SYNC_RST;
			second_sync_q <= tfd_pkg::SECOND_SYNC_RST;
			close_byte_q  <= tfd_pkg::CLOSE_BYTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tfd_pkg::CFG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				tfd_pkg::CFG_SECOND_SYNC: second_sync_q <= cfg_data;
				tfd_pkg::CFG_CLOSE_BYTE:  close_byte_q  <= cfg_data;
				default: ; // unknown index: write ignored
			endcase
		end
	end

	// input register: control cleared on reset, payload free-running on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			byte_s1   <= byte_value;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		stamp_d   = stamp_q;
		length_d  = length_q;
		elapsed_d = elapsed_q;
		event_d   = tfd_pkg::EV_NONE;
		pbyte_d   = 8'd0;
		pindex_d  = 8'd0;
		fstamp_d  = 32'd0;
		flength_d = 8'd0;

		if (action_s1 == tfd_pkg::ACT_TICK) begin
			// saturating tick count; release compares against the bumped value
			if (elapsed_q != 32'hFFFF_FFFF) begin
				elapsed_d = elapsed_q + 32'd1;
			end
			if (state_q == tfd_pkg::ST_HELD && elapsed_d > stamp_q) begin
				event_d   = tfd_pkg::EV_RELEASE;
				fstamp_d  = stamp_q;
				flength_d = length_q;
				state_d   = tfd_pkg::ST_SYNC0;
			end
		end else begin
			case (state_q)
				tfd_pkg::ST_SYNC0: begin
					if (byte_s1 == first_sync_q) begin
						state_d = tfd_pkg::ST_SYNC1;
					end else begin
						state_d = tfd_pkg::ST_LOST;
						event_d = tfd_pkg::EV_LOST;
					end
				end
				tfd_pkg::ST_SYNC1: begin
					if (byte_s1 == second_sync_q) begin
						state_d = tfd_pkg::ST_STAMP;
						count_d = 8'd0;
						stamp_d = 32'd0;
					end else begin
						state_d = tfd_pkg::ST_LOST;
						event_d = tfd_pkg::EV_LOST;
					end
				end
				tfd_pkg::ST_STAMP: begin
					// little-endian: byte lane picked by low counter bits
					case (count_q[1:0])
						2'd0:    stamp_d[7:0]   = stamp_q[7:0]   | byte_s1;
						2'd1:    stamp_d[15:8]  = stamp_q[15:8]  | byte_s1;
						2'd2:    stamp_d[23:16] = stamp_q[23:16] | byte_s1;
						default: stamp_d[31:24] = stamp_q[31:24] | byte_s1;
					endcase
					count_d = count_inc;
					if (count_inc >= tfd_pkg::STAMP_BYTES) begin
						state_d = tfd_pkg::ST_LENGTH;
					end
				end
				tfd_pkg::ST_LENGTH: begin
					length_d = byte_s1;
					count_d  = 8'd0;
					// empty frame goes straight to the end marker
					state_d  = (byte_s1 == 8'd0) ? tfd_pkg::ST_END : tfd_pkg::ST_DATA;
				end
				tfd_pkg::ST_DATA: begin
					event_d  = tfd_pkg::EV_PAYLOAD;
					pbyte_d  = byte_s1;
					pindex_d = count_q;
					count_d  = count_inc;
					if (count_inc == length_q) begin
						state_d = tfd_pkg::ST_END;
					end
				end
				tfd_pkg::ST_END: begin
					if (byte_s1 == close_byte_q) begin
						state_d = tfd_pkg::ST_HELD;
					end else begin
						state_d = tfd_pkg::ST_LOST;
						event_d = tfd_pkg::EV_LOST;
					end
				end
				tfd_pkg::ST_HELD: begin
					event_d = tfd_pkg::EV_DROPPED;
				end
				default: begin
					// lost sync: swallow this byte, then hunt again
					state_d = tfd_pkg::ST_SYNC0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tfd_pkg::ST_SYNC0;
			count_q   <= 8'd0;
			stamp_q   <= 32'd0;
			length_q  <= 8'd0;
			elapsed_q <= 32'd0;
		end else if (advance) begin
			state_q   <= state_d;
			count_q   <= count_d;
			stamp_q   <= stamp_d;
			length_q  <= length_d;
			elapsed_q <= elapsed_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q   <= event_d;
			pbyte_q   <= pbyte_d;
			pindex_q  <= pindex_d;
			fstamp_q  <= fstamp_d;
			flength_q <= flength_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = event_q;
	assign payload_byte  = pbyte_q;
	assign payload_index = pindex_q;
	assign frame_stamp   = fstamp_q;
	assign frame_length  = flength_q;

	// payload fields are zero unless the beat carries a payload byte
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q != tfd_pkg::EV_PAYLOAD |-> pbyte_q == 8'd0 && pindex_q == 8'd0)
		else $error("payload fields set on a non-payload result");

	// frame fields are zero unless the beat is a release
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q != tfd_pkg::EV_RELEASE |-> fstamp_q == 32'd0 && flength_q == 8'd0)
		else $error("frame fields set on a non-release result");

	// the elapsed count never goes backwards
	a_elapsed_mono: assert property (@(posedge clk) disable iff (!arst_n)
		elapsed_q >= $past(elapsed_q))
		else $error("elapsed count decreased");

	// a pending release result means the parser has restarted the hunt
	a_release_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q == tfd_pkg::EV_RELEASE |-> state_q == tfd_pkg::ST_SYNC0)
		else $error("parser not restarted after release");

endmodule
